// ===== rtl/stb_pkg.sv =====
// shared types, constants and sizes for the software timer bank
package stb_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int NREP_W = $clog2(MAX_RESULTS + 1);

    // fixed field widths of the ports
    localparam int OP_W     = 3;
    localparam int TIDX_W   = 4;
    localparam int IN_CNT_W = 32;
    localparam int KIND_W   = 2;
    localparam int TST_W    = 3;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_DESTROY = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [TST_W-1:0] {
        ST_UNUSED    = 3'd0,
        ST_CREATED   = 3'd1,
        ST_STARTED   = 3'd2,
        ST_STOPPED   = 3'd3,
        ST_DESTROYED = 3'd4
    } tstate_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef struct packed {
        cnt_t    delay;
        cnt_t    period;
        cnt_t    count;
        logic    hard;
        tstate_t state;
    } entry_t;

    // delay, or the period when the delay is zero
    function automatic cnt_t load_value(cnt_t delay, cnt_t period);
        return (delay != '0) ? delay : period;
    endfunction

endpackage

// ===== rtl/stb_ram.sv =====
// generic single-write, single-read ram with registered read data
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/software_timer_bank.sv =====
// bank of software timers: operations on one timer, ticks that walk the whole bank
//
// input channel (in_valid/in_ready) takes one word per operation: init, start,
// stop and destroy address one timer, tick serves the whole bank. the block
// works on one word at a time; in_ready is high only while it is idle.
// output channel (out_valid/out_ready) carries result words from one output
// register; last marks the final result of an input word.
// an operation gives one acknowledgement, registered once the output is free.
// a tick reads and updates each timer entry in the state ram and writes back
// those that take part, once for the hard class and once for the soft class,
// one entry at a time through the single ram read port (read, then update).
// fires go out hard first, then soft, each in ascending index; a tick with
// no fire gives one idle result.
// reset marks every entry as never written, so every timer reads as unused
// with zero counts; no clearing pass is needed.
// when the receiver stalls, the walk holds at the next reported fire (or the
// end of the tick) until the output register is taken.
module software_timer_bank
    import stb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [TIDX_W-1:0]   timer_index,
    input  logic [IN_CNT_W-1:0] start_delay,
    input  logic [IN_CNT_W-1:0] period,
    input  logic                hard_mode,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [TIDX_W-1:0]   fired_index,
    output logic [TST_W-1:0]    state_after,
    output logic                applied,
    output logic                last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_TRD  = 5'b00100,
        S_TUPD = 5'b01000,
        S_TEND = 5'b10000
    } fsm_t;

    fsm_t state_reg, state_next;

    // latched input word
    logic [OP_W-1:0]   op_reg;
    logic [TIDX_W-1:0] idx_reg;
    cnt_t              delay_reg;
    cnt_t              period_reg;
    logic              hard_reg;

    // walk control
    logic [IDX_W-1:0]  t_reg, t_next;
    logic              cls_reg, cls_next;
    logic [NREP_W-1:0] nrep_reg, nrep_next;

    // fire held back until we know whether it is the last one
    logic              pend_vld_reg, pend_vld_next;
    logic [TIDX_W-1:0] pend_idx_reg, pend_idx_next;
    tstate_t           pend_st_reg, pend_st_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    kind_t             kind_reg, kind_next;
    logic [TIDX_W-1:0] fidx_reg, fidx_next;
    tstate_t           st_reg, st_next;
    logic              applied_reg, applied_next;
    logic              last_reg, last_next;

    // entry valid bits stand in for a ram clear
    logic [NUM_TIMERS-1:0] vld_reg, vld_next;
    logic                  rd_vld_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    entry_t           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_q;

    entry_t ent;
    logic   can_load;
    logic   in_range_in;
    logic   in_range;
    logic   accept;

    // execution of a single-timer operation
    entry_t  op_ent;
    logic    op_applied;

    // tick update of one entry
    logic    t_part;
    logic    t_fire;
    cnt_t    t_dec;
    entry_t  t_ent;
    logic    t_report;
    logic    t_last;

    stb_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (NUM_TIMERS),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign ent         = rd_vld_reg ? entry_t'(ram_q) : '0;
    assign can_load    = !out_valid_reg || out_ready;
    assign in_range_in = int'(timer_index) < NUM_TIMERS;
    assign in_range    = int'(idx_reg) < NUM_TIMERS;
    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;

    // single-timer operation on the entry just read
    always_comb
    begin
        op_ent     = ent;
        op_applied = 1'b0;
        case (op_reg)
            OP_INIT:
            begin
                op_ent.delay  = delay_reg;
                op_ent.period = period_reg;
                op_ent.hard   = hard_reg;
                op_ent.count  = load_value(delay_reg, period_reg);
                op_ent.state  = ST_CREATED;
                op_applied    = 1'b1;
            end
            OP_START:
            begin
                if (ent.state == ST_CREATED || ent.state == ST_STOPPED)
                begin
                    op_ent.count = load_value(ent.delay, ent.period);
                    op_ent.state = ST_STARTED;
                    op_applied   = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (ent.state == ST_STARTED)
                begin
                    op_ent.state = ST_STOPPED;
                    op_applied   = 1'b1;
                end
            end
            OP_DESTROY:
            begin
                if (ent.state != ST_DESTROYED)
                begin
                    op_ent.state = ST_DESTROYED;
                    op_applied   = 1'b1;
                end
            end
            default:
            begin
                op_applied = 1'b0;
            end
        endcase
    end

    // one tick step on the entry just read
    always_comb
    begin
        t_part = (ent.state == ST_STARTED) && (ent.hard == cls_reg);
        t_dec  = ent.count - cnt_t'(1);
        t_fire = (ent.count == '0) || (t_dec == '0);
        t_ent  = ent;
        if (t_fire && ent.period != '0)
        begin
            t_ent.count = ent.period;
        end
        else if (ent.count != '0)
        begin
            t_ent.count = t_dec;
        end
        if (t_fire && ent.period == '0)
        begin
            t_ent.state = ST_STOPPED;
        end
        t_report = nrep_reg < NREP_W'(MAX_RESULTS);
        t_last   = (t_reg == IDX_W'(NUM_TIMERS - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        t_next         = t_reg;
        cls_next       = cls_reg;
        nrep_next      = nrep_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        pend_st_next   = pend_st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        fidx_next      = fidx_reg;
        st_next        = st_reg;
        applied_next   = applied_reg;
        last_next      = last_reg;
        vld_next       = vld_reg;
        ram_we         = 1'b0;
        ram_waddr      = t_reg;
        ram_wdata      = t_ent;
        ram_re         = 1'b0;
        ram_raddr      = t_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_TICK)
                    begin
                        t_next        = '0;
                        cls_next      = 1'b1;
                        nrep_next     = '0;
                        pend_vld_next = 1'b0;
                        state_next    = S_TRD;
                    end
                    else
                    begin
                        ram_re     = in_range_in;
                        ram_raddr  = IDX_W'(timer_index);
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_ACK;
                    fidx_next      = idx_reg;
                    last_next      = 1'b1;
                    if (in_range)
                    begin
                        st_next      = op_ent.state;
                        applied_next = op_applied;
                        ram_we       = op_applied;
                        ram_waddr    = IDX_W'(idx_reg);
                        ram_wdata    = op_ent;
                        if (op_applied)
                        begin
                            vld_next[IDX_W'(idx_reg)] = 1'b1;
                        end
                    end
                    else
                    begin
                        st_next      = ST_UNUSED;
                        applied_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                ram_re     = 1'b1;
                state_next = S_TUPD;
            end
            S_TUPD:
            begin
                // a reported fire pushes the held one out first
                if (!(t_part && t_fire && t_report && pend_vld_reg && !can_load))
                begin
                    if (t_part)
                    begin
                        ram_we = 1'b1;
                        vld_next[t_reg] = 1'b1;
                    end
                    if (t_part && t_fire && t_report)
                    begin
                        if (pend_vld_reg)
                        begin
                            out_valid_next = 1'b1;
                            kind_next      = KIND_FIRED;
                            fidx_next      = pend_idx_reg;
                            st_next        = pend_st_reg;
                            applied_next   = 1'b1;
                            last_next      = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = TIDX_W'(t_reg);
                        pend_st_next  = t_ent.state;
                        nrep_next     = nrep_reg + NREP_W'(1);
                    end
                    if (t_last)
                    begin
                        t_next = '0;
                        if (cls_reg)
                        begin
                            cls_next   = 1'b0;
                            state_next = S_TRD;
                        end
                        else
                        begin
                            state_next = S_TEND;
                        end
                    end
                    else
                    begin
                        t_next     = t_reg + IDX_W'(1);
                        state_next = S_TRD;
                    end
                end
            end
            S_TEND:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b1;
                    if (pend_vld_reg)
                    begin
                        kind_next    = KIND_FIRED;
                        fidx_next    = pend_idx_reg;
                        st_next      = pend_st_reg;
                        applied_next = 1'b1;
                    end
                    else
                    begin
                        kind_next    = KIND_IDLE;
                        fidx_next    = '0;
                        st_next      = ST_UNUSED;
                        applied_next = 1'b0;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            t_reg         <= '0;
            cls_reg       <= 1'b0;
            nrep_reg      <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            t_reg         <= t_next;
            cls_reg       <= cls_next;
            nrep_reg      <= nrep_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
            vld_reg       <= vld_next;
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[ram_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            idx_reg    <= timer_index;
            delay_reg  <= cnt_t'(start_delay);
            period_reg <= cnt_t'(period);
            hard_reg   <= hard_mode;
        end
        pend_idx_reg <= pend_idx_next;
        pend_st_reg  <= pend_st_next;
        kind_reg     <= kind_next;
        fidx_reg     <= fidx_next;
        st_reg       <= st_next;
        applied_reg  <= applied_next;
        last_reg     <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign fired_index = fidx_reg;
    assign state_after = st_reg;
    assign applied     = applied_reg;
    assign last        = last_reg;

endmodule
